/* src/rrt_pkg.sv */
`timescale 1ns / 1ps

package rrt_pkg;

   // Field and register widths
   localparam int unsigned TIMER_W  = 16;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned SUM_W    = 20;
   localparam int unsigned AVG_W    = 23;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Reciprocal scaling for the average: avg = (sum * RECIP) >> AVG_SHIFT.
   // Exact for sum < 2**20 and a divisor of up to 16.
   localparam int unsigned AVG_SHIFT = 24;
   localparam int unsigned RECIP_W   = 31;

   // Register reset values
   localparam logic [TIMER_W-1:0] START_DELAY_RST = 16'd2000;
   localparam logic [TIMER_W-1:0] PAUSE_RST       = 16'd1000;
   localparam logic               ACTIVE_LOW_RST  = 1'b1;

   // Measurement phases, codes as seen on the rsp_phase port
   typedef enum logic [1:0] {
      PH_DELAY = 2'd0,
      PH_WAIT  = 2'd1,
      PH_PAUSE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_DELAY = 2'd0,
      CSR_PAUSE       = 2'd1,
      CSR_ACTIVE_LOW  = 2'd2
   } csr_index_type;

   // Saturating 16-bit increment
   function automatic logic [TIMER_W-1:0] sat_inc16(input logic [TIMER_W-1:0] v);
      sat_inc16 = (v == '1) ? v : v + TIMER_W'(1);
   endfunction

endpackage

/* src/rrt_avg.sv */
`timescale 1ns / 1ps

// Average in hundredths: floor(sum * 100 / MEAS_COUNT) by a constant
// reciprocal multiply, registered, so it follows the running sum in the next cycle.
module rrt_avg #(
   parameter int MEAS_COUNT = 10
) (
   input  logic                      clock,
   input  logic [rrt_pkg::SUM_W-1:0] sum,
   output logic [rrt_pkg::AVG_W-1:0] avg
);
   import rrt_pkg::*;

   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd100 << AVG_SHIFT) + 64'(MEAS_COUNT) - 64'd1) / 64'(MEAS_COUNT));

   logic [SUM_W+RECIP_W-1:0] prod;
   logic [AVG_W-1:0]         avg_ff;
   logic [AVG_W-1:0]         avg_in;

   assign prod   = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP);
   assign avg_in = prod[AVG_SHIFT +: AVG_W];

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   assign avg = avg_ff;

endmodule

/* src/relay_response_time_tester_unit.sv */
`timescale 1ns / 1ps

// Relay response time tester.
// Each item on the req_ channel is one millisecond tick; req_contact_fell
// flags a falling contact edge in that tick. Every accepted item gives
// exactly one item on the rsp_ channel: relay pin level, phase, and, on the
// ticks concerned, a completed sample or the final average (hundredths of
// a millisecond, reported once after MEAS_COUNT measurements).
// The result of an item is registered and is in the output register
// in the cycle after acceptance. One item per cycle is sustained while
// rsp_ready is high; the output register is refilled in the cycle it
// is taken, so req_ready follows rsp_ready while a result is held. If
// the receiver stalls, the result holds and req_ready drops until it
// is taken. The csr_ channel writes start delay, pause and relay
// polarity; it is always ready. It must be written only while no item
// is in flight; the block does not enforce this. Reset (synchronous)
// returns to the start delay phase with cleared counters, drops rsp_valid
// and restores register defaults (2000 ms, 1000 ms, active low).
module relay_response_time_tester_unit #(
   parameter int MEAS_COUNT = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   // tick input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_contact_fell,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_relay_level,
   output logic [1:0]                     rsp_phase,
   output logic                           rsp_sample_valid,
   output logic [rrt_pkg::COUNT_W-1:0]    rsp_sample_number,
   output logic [rrt_pkg::TIMER_W-1:0]    rsp_sample_ms,
   output logic                           rsp_average_valid,
   output logic [rrt_pkg::AVG_W-1:0]      rsp_average_centi_ms,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rrt_pkg::*;

   // configuration
   logic [TIMER_W-1:0] start_delay_ff;
   logic [TIMER_W-1:0] pause_ff;
   logic               active_low_ff;

   // measurement state
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] phase_timer_ff, phase_timer_in;
   logic [TIMER_W-1:0] resp_timer_ff, resp_timer_in;
   logic [COUNT_W-1:0] done_count_ff, done_count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               avg_reported_ff, avg_reported_in;

   // output register
   logic               rsp_valid_ff;
   logic               relay_level_ff, relay_level_in;
   logic [1:0]         phase_out_ff;
   logic               sample_valid_ff, sample_valid_in;
   logic [COUNT_W-1:0] sample_number_ff, sample_number_in;
   logic [TIMER_W-1:0] sample_ms_ff, sample_ms_in;
   logic               avg_valid_ff, avg_valid_in;
   logic [AVG_W-1:0]   avg_out_ff, avg_out_in;

   logic               accept;
   logic [TIMER_W-1:0] pt_inc;
   logic [TIMER_W-1:0] rt_inc;
   logic [AVG_W-1:0]   avg_val;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign pt_inc = sat_inc16(phase_timer_ff);
   assign rt_inc = sat_inc16(resp_timer_ff);

   // average of the running sum, registered; settles in the cycle after sum_ff takes the last sample
   rrt_avg #(
      .MEAS_COUNT(MEAS_COUNT)
   ) u_avg (
      .clock (clock),
      .sum   (sum_ff),
      .avg   (avg_val)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= START_DELAY_RST;
         pause_ff       <= PAUSE_RST;
         active_low_ff  <= ACTIVE_LOW_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_DELAY: start_delay_ff <= csr_wdata;
            CSR_PAUSE:       pause_ff       <= csr_wdata;
            CSR_ACTIVE_LOW:  active_low_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state for one tick
   always_comb begin
      phase_in        = phase_ff;
      phase_timer_in  = phase_timer_ff;
      resp_timer_in   = resp_timer_ff;
      done_count_in   = done_count_ff;
      sum_in          = sum_ff;
      avg_reported_in = avg_reported_ff;
      unique case (phase_ff)
         PH_DELAY: begin
            phase_timer_in = pt_inc;
            if (pt_inc >= start_delay_ff) begin
               phase_in      = PH_WAIT;
               resp_timer_in = '0;
            end
         end
         PH_WAIT: begin
            resp_timer_in = rt_inc;
            if (req_contact_fell) begin
               done_count_in  = done_count_ff + COUNT_W'(1);
               sum_in         = sum_ff + SUM_W'(rt_inc);
               phase_in       = PH_PAUSE;
               phase_timer_in = '0;
            end
         end
         PH_PAUSE: begin
            phase_timer_in = pt_inc;
            if (pt_inc >= pause_ff) begin
               phase_timer_in = '0;
               if (done_count_ff >= COUNT_W'(MEAS_COUNT)) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in      = PH_WAIT;
                  resp_timer_in = '0;
               end
            end
         end
         PH_DONE: begin
            avg_reported_in = 1'b1;
         end
         default: ;
      endcase
   end

   // result fields for one tick
   always_comb begin
      sample_valid_in  = 1'b0;
      sample_number_in = '0;
      sample_ms_in     = '0;
      avg_valid_in     = 1'b0;
      avg_out_in       = '0;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_contact_fell) begin
               sample_valid_in  = 1'b1;
               sample_number_in = done_count_in;
               sample_ms_in     = rt_inc;
            end
         end
         PH_DONE: begin
            if (!avg_reported_ff) begin
               avg_valid_in = 1'b1;
               avg_out_in   = avg_val;
            end
         end
         default: ;
      endcase
      relay_level_in = (phase_in == PH_WAIT) ^ active_low_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_DELAY;
         phase_timer_ff  <= '0;
         resp_timer_ff   <= '0;
         done_count_ff   <= '0;
         sum_ff          <= '0;
         avg_reported_ff <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         phase_timer_ff  <= phase_timer_in;
         resp_timer_ff   <= resp_timer_in;
         done_count_ff   <= done_count_in;
         sum_ff          <= sum_in;
         avg_reported_ff <= avg_reported_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         relay_level_ff   <= relay_level_in;
         phase_out_ff     <= phase_in;
         sample_valid_ff  <= sample_valid_in;
         sample_number_ff <= sample_number_in;
         sample_ms_ff     <= sample_ms_in;
         avg_valid_ff     <= avg_valid_in;
         avg_out_ff       <= avg_out_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_relay_level      = relay_level_ff;
   assign rsp_phase            = phase_out_ff;
   assign rsp_sample_valid     = sample_valid_ff;
   assign rsp_sample_number    = sample_number_ff;
   assign rsp_sample_ms        = sample_ms_ff;
   assign rsp_average_valid    = avg_valid_ff;
   assign rsp_average_centi_ms = avg_out_ff;

endmodule

/* src/rrt_checker.sv */
`timescale 1ns / 1ps

module rrt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_phase,
   input logic                        rsp_sample_valid,
   input logic [rrt_pkg::COUNT_W-1:0] rsp_sample_number,
   input logic                        rsp_average_valid
);
   import rrt_pkg::*;

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_sample_valid) && $stable(rsp_average_valid))
      else $error("rsp item changed while stalled");

   // a completed sample always moves the tester into the pause
   a_sample_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> rsp_phase == PH_PAUSE && rsp_sample_number != '0)
      else $error("sample reported outside pause entry");

   // the average only appears once finished
   a_avg_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_average_valid |-> rsp_phase == PH_DONE && !rsp_sample_valid)
      else $error("average reported outside finished phase");

   // every accepted item yields a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind relay_response_time_tester_unit rrt_checker u_rrt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_phase         (rsp_phase),
   .rsp_sample_valid  (rsp_sample_valid),
   .rsp_sample_number (rsp_sample_number),
   .rsp_average_valid (rsp_average_valid)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import rrt_pkg::*;

   localparam int          MEAS_COUNT   = 10;
   localparam int          RANDOM_TICKS = 1000;
   localparam int          LONG_TICKS   = 150;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   // One result item as the block reports it
   typedef struct packed {
      logic                relay_level;
      phase_type           phase;
      logic                sample_valid;
      logic [COUNT_W-1:0]  sample_number;
      logic [TIMER_W-1:0]  sample_ms;
      logic                average_valid;
      logic [AVG_W-1:0]    average_centi_ms;
   } tick_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_contact_fell;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_relay_level;
   logic [1:0]            rsp_phase;
   logic                  rsp_sample_valid;
   logic [COUNT_W-1:0]    rsp_sample_number;
   logic [TIMER_W-1:0]    rsp_sample_ms;
   logic                  rsp_average_valid;
   logic [AVG_W-1:0]      rsp_average_centi_ms;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Register copies as the block should hold them
   logic [TIMER_W-1:0]    delay_setting    = START_DELAY_RST;
   logic [TIMER_W-1:0]    pause_setting    = PAUSE_RST;
   logic                  drive_active_low = ACTIVE_LOW_RST;

   // Measurement state as the block should hold it
   phase_type             cur_phase     = PH_DELAY;
   logic [TIMER_W-1:0]    phase_ticks   = '0;
   logic [TIMER_W-1:0]    response_ticks = '0;
   logic [COUNT_W-1:0]    samples_done  = '0;
   logic [SUM_W-1:0]      response_sum  = '0;
   logic                  average_sent  = 1'b0;

   tick_result_type       awaited_results[$];
   int unsigned           error_count   = 0;
   int unsigned           results_seen  = 0;
   int unsigned           rx_stall_left = 0;
   logic                  quiet         = 1'b0;

   relay_response_time_tester_unit #(
      .MEAS_COUNT(MEAS_COUNT)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_contact_fell    (req_contact_fell),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_relay_level     (rsp_relay_level),
      .rsp_phase           (rsp_phase),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_sample_number   (rsp_sample_number),
      .rsp_sample_ms       (rsp_sample_ms),
      .rsp_average_valid   (rsp_average_valid),
      .rsp_average_centi_ms(rsp_average_centi_ms),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Timer step that sticks at full scale
   function automatic logic [TIMER_W-1:0] timer_step(input logic [TIMER_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Advance the measurement state by one tick and give the result it causes
   function automatic tick_result_type advance_tick(input logic fell);
      tick_result_type r;
      r = '0;
      case (cur_phase)
         PH_DELAY: begin
            phase_ticks = timer_step(phase_ticks);
            if (phase_ticks >= delay_setting) begin
               cur_phase      = PH_WAIT;
               response_ticks = '0;
            end
         end
         PH_WAIT: begin
            response_ticks = timer_step(response_ticks);
            if (fell) begin
               samples_done    = samples_done + 1'b1;
               response_sum    = response_sum + SUM_W'(response_ticks);
               r.sample_valid  = 1'b1;
               r.sample_ms     = response_ticks;
               r.sample_number = samples_done;
               cur_phase       = PH_PAUSE;
               phase_ticks     = '0;
            end
         end
         PH_PAUSE: begin
            phase_ticks = timer_step(phase_ticks);
            if (phase_ticks >= pause_setting) begin
               phase_ticks = '0;
               if (samples_done >= MEAS_COUNT) begin
                  cur_phase = PH_DONE;
               end else begin
                  cur_phase      = PH_WAIT;
                  response_ticks = '0;
               end
            end
         end
         default: begin
            if (!average_sent) begin
               average_sent       = 1'b1;
               r.average_valid    = 1'b1;
               r.average_centi_ms = AVG_W'((32'(response_sum) * 32'd100) / MEAS_COUNT);
            end
         end
      endcase
      r.phase       = cur_phase;
      r.relay_level = (cur_phase == PH_WAIT) ^ drive_active_low;
      return r;
   endfunction

   // Idle length for either side: mostly none, some short, a few long
   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
   endtask

   // Result side: random stalls, each item checked against the oldest expectation
   initial begin
      tick_result_type want;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               report_error($sformatf("result %0d arrived with none expected", results_seen));
            end else begin
               want = awaited_results.pop_front();
               compare_field("relay_level", 32'(rsp_relay_level), 32'(want.relay_level));
               compare_field("phase", 32'(rsp_phase), 32'(want.phase));
               compare_field("sample_valid", 32'(rsp_sample_valid),
                             32'(want.sample_valid));
               compare_field("sample_number", 32'(rsp_sample_number),
                             32'(want.sample_number));
               compare_field("sample_ms", 32'(rsp_sample_ms), 32'(want.sample_ms));
               compare_field("average_valid", 32'(rsp_average_valid),
                             32'(want.average_valid));
               compare_field("average_centi_ms", 32'(rsp_average_centi_ms),
                             32'(want.average_centi_ms));
            end
         end
         if (rx_stall_left != 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rx_stall_left = idle_len();
            rsp_ready <= (rx_stall_left == 0);
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("relay_response_time_tester_unit test failed");
      $finish;
   end

   // Send one tick item, record what it should cause, then maybe idle
   task automatic send_tick(input logic fell);
      int unsigned gap;
      req_valid        <= 1'b1;
      req_contact_fell <= fell;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_results.push_back(advance_tick(fell));
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_DELAY: delay_setting    = data;
         CSR_PAUSE:       pause_setting    = data;
         default:         drive_active_low = data[0];
      endcase
   endtask

   // Start delay: edges ignored, widest setting, then cut short mid-phase
   task automatic test_start_delay();
      repeat (3) send_tick(1'b1);
      write_reg(CSR_START_DELAY, '1);
      send_tick(1'b1);
      send_tick(1'b0);
      write_reg(CSR_PAUSE, '0);
      write_reg(CSR_ACTIVE_LOW, '0);
      write_reg(CSR_START_DELAY, '0);
      // edge on the tick that enters waiting must not count
      send_tick(1'b1);
   endtask

   // Edge on the first waiting tick, zero pause, a short response
   task automatic test_quick_response();
      send_tick(1'b1);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // Widest pause, then shortened below the elapsed time; polarity flip while energised
   task automatic test_pause_change();
      write_reg(CSR_PAUSE, '1);
      repeat (3) send_tick(1'b1);
      write_reg(CSR_PAUSE, 16'd2);
      send_tick(1'b0);
      write_reg(CSR_ACTIVE_LOW, 16'd1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // A longer response, both sides without idling
   task automatic test_long_response();
      write_reg(CSR_PAUSE, 16'd5);
      quiet = 1'b1;
      while (cur_phase != PH_WAIT) send_tick(1'($urandom_range(0, 1)));
      repeat (LONG_TICKS) send_tick(1'b0);
      send_tick(1'b1);
      quiet = 1'b0;
   endtask

   // Random measurements with register writes dropped in between items
   task automatic test_random_ticks();
      csr_index_type reg_list[3];
      csr_index_type idx;
      logic          fell;
      reg_list = '{CSR_START_DELAY, CSR_PAUSE, CSR_ACTIVE_LOW};
      for (int n = 0; n < RANDOM_TICKS; n++) begin
         if ($urandom_range(0, 149) == 0) begin
            idx = reg_list[$urandom_range(0, 2)];
            if (idx == CSR_PAUSE)
               write_reg(idx, CSR_DATA_W'($urandom_range(0, 80)));
            else
               write_reg(idx, CSR_DATA_W'($urandom));
         end
         if (cur_phase == PH_WAIT)
            fell = ($urandom_range(0, 39) == 0);
         else
            fell = 1'($urandom_range(0, 1));
         send_tick(fell);
      end
   endtask

   // Run on into the finished phase: one average, then nothing but the relay level
   task automatic test_finished();
      while (cur_phase != PH_DONE || !average_sent)
         send_tick((cur_phase == PH_WAIT) ? ($urandom_range(0, 9) == 0) : 1'b1);
      write_reg(CSR_ACTIVE_LOW, CSR_DATA_W'(!drive_active_low));
      repeat (10) send_tick(1'($urandom_range(0, 1)));
      write_reg(CSR_ACTIVE_LOW, CSR_DATA_W'(!drive_active_low));
      repeat (10) send_tick(1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_contact_fell <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_START_DELAY;
      csr_wdata        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_start_delay();
      test_quick_response();
      test_pause_change();
      test_long_response();
      test_random_ticks();
      test_finished();

      drain();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("relay_response_time_tester_unit test passed");
      else
         $display("relay_response_time_tester_unit test failed");
      $finish;
   end

endmodule

/* filelist.f */
src/rrt_pkg.sv
src/rrt_avg.sv
src/relay_response_time_tester_unit.sv
src/rrt_checker.sv
dv/testbench.sv
